// File: rtl/bfea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit extent allocator package
// Shared widths, status codes, controller states and control structs.
// ----------------------------------------------------------------------------
package bfea_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int INDEX_BITS  = 24;

  localparam int IDX_W  = $clog2(MAX_EXTENTS);
  localparam int ADDR_W = INDEX_BITS;
  localparam int SIZE_W = INDEX_BITS + 1;
  localparam int END_W  = SIZE_W + 1;
  localparam int SUM_W  = SIZE_W + IDX_W;

  localparam logic [SIZE_W-1:0] TOTAL_MAX  = {1'b1, {ADDR_W{1'b0}}};
  localparam logic [IDX_W-1:0]  LAST_ENTRY = IDX_W'(MAX_EXTENTS - 1);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_IGN  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_APPLY,
    S_SUM,
    S_SUM_END,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic             init;
    logic             cfg_load;
    logic             req_load;
    logic             rd_en;
    logic             rd_sum;
    logic [IDX_W-1:0] rd_addr;
    logic             apply;
    logic             finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ctrl_stat_t;

endpackage

// File: rtl/bfea_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit extent allocator channels
// Request, result and size-register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bfea_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [bfea_pkg::SIZE_W-1:0]   block_size;
  logic [bfea_pkg::ADDR_W-1:0]   block_start;

  modport source (output valid, req_type, block_size, block_start, input ready);
  modport sink   (input valid, req_type, block_size, block_start, output ready);
endinterface

interface bfea_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [bfea_pkg::ADDR_W-1:0]   granted_start;
  logic [bfea_pkg::SIZE_W-1:0]   granted_size;
  logic [bfea_pkg::SIZE_W-1:0]   free_elements;
  logic [bfea_pkg::SIZE_W-1:0]   used_elements;

  modport source (output valid, status, granted_start, granted_size, free_elements,
                  used_elements, input ready);
  modport sink   (input valid, status, granted_start, granted_size, free_elements,
                  used_elements, output ready);
endinterface

interface bfea_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bfea_pkg::SIZE_W-1:0]   total_elements;

  modport source (output valid, total_elements, input ready);
  modport sink   (input valid, total_elements, output ready);
endinterface

// File: rtl/bfea_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit extent allocator controller
// Sequences table init, the search pass, the table update and the recount pass.
// ----------------------------------------------------------------------------
module bfea_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  bfea_pkg::ctrl_stat_t  stat,
  output bfea_pkg::ctrl_cmd_t   cmd
);

  bfea_pkg::ctrl_state_t         state_r, state_nxt;
  logic [bfea_pkg::IDX_W-1:0]    cnt_r, cnt_nxt;

  // State and entry counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfea_pkg::S_INIT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.rd_addr = cnt_r;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    unique case (state_r)
      bfea_pkg::S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = bfea_pkg::S_IDLE;
      end
      bfea_pkg::S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_load = 1'b1;
          state_nxt    = bfea_pkg::S_INIT;
        end else if (in_valid) begin
          cmd.req_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = bfea_pkg::S_SCAN;
        end
      end
      bfea_pkg::S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt_r == bfea_pkg::LAST_ENTRY) begin
          cnt_nxt   = '0;
          state_nxt = bfea_pkg::S_SCAN_END;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      bfea_pkg::S_SCAN_END: begin
        state_nxt = bfea_pkg::S_APPLY;
      end
      bfea_pkg::S_APPLY: begin
        cmd.apply = 1'b1;
        cnt_nxt   = '0;
        state_nxt = bfea_pkg::S_SUM;
      end
      bfea_pkg::S_SUM: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sum = 1'b1;
        if (cnt_r == bfea_pkg::LAST_ENTRY) begin
          cnt_nxt   = '0;
          state_nxt = bfea_pkg::S_SUM_END;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      bfea_pkg::S_SUM_END: begin
        state_nxt = bfea_pkg::S_DONE;
      end
      bfea_pkg::S_DONE: begin
        // Hold until the result register is free
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = bfea_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bfea_pkg::S_INIT;
      end
    endcase
  end

endmodule

// File: rtl/bfea_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit extent allocator datapath
// Extent table memory, scan evaluation, table update, recount and result register.
// ----------------------------------------------------------------------------
module bfea_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bfea_pkg::ctrl_cmd_t           cmd,
  output bfea_pkg::ctrl_stat_t          stat,
  input  logic [bfea_pkg::SIZE_W-1:0]   cfg_total,
  input  logic                          in_req_type,
  input  logic [bfea_pkg::SIZE_W-1:0]   in_block_size,
  input  logic [bfea_pkg::ADDR_W-1:0]   in_block_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [bfea_pkg::ADDR_W-1:0]   out_granted_start,
  output logic [bfea_pkg::SIZE_W-1:0]   out_granted_size,
  output logic [bfea_pkg::SIZE_W-1:0]   out_free_elements,
  output logic [bfea_pkg::SIZE_W-1:0]   out_used_elements
);

  localparam int IW = bfea_pkg::IDX_W;
  localparam int AW = bfea_pkg::ADDR_W;
  localparam int SW = bfea_pkg::SIZE_W;
  localparam int EW = bfea_pkg::END_W;

  // Extent table
  logic [AW-1:0] mem_beg [bfea_pkg::MAX_EXTENTS];
  logic [SW-1:0] mem_len [bfea_pkg::MAX_EXTENTS];
  logic [bfea_pkg::MAX_EXTENTS-1:0] valid_r;

  logic [SW-1:0] total_r;
  logic          type_r;
  logic [SW-1:0] size_r;
  logic [AW-1:0] start_r;

  logic [AW-1:0] rd_beg_r;
  logic [SW-1:0] rd_len_r;
  logic          rd_val_r, rd_pend_r, rd_sum_r;
  logic [IW-1:0] rd_idx_r;

  logic          best_fnd_r, aft_fnd_r, bef_fnd_r, slot_fnd_r;
  logic [IW-1:0] best_idx_r, aft_idx_r, bef_idx_r, slot_idx_r;
  logic [AW-1:0] best_beg_r, aft_beg_r, bef_beg_r;
  logic [SW-1:0] best_len_r, aft_len_r;
  logic [bfea_pkg::SUM_W-1:0] sum_r;

  bfea_pkg::status_t st_r, st_nxt;
  logic [AW-1:0] gstart_r, gstart_nxt;
  logic [SW-1:0] gsize_r, gsize_nxt;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [AW-1:0] out_gstart_r;
  logic [SW-1:0] out_gsize_r, out_free_r, out_used_r;

  logic [EW-1:0] req_end, rd_end, new_end;
  logic [AW-1:0] new_beg;
  logic          wr_en, clr_en, set_en;
  logic [IW-1:0] wr_idx, clr_idx;
  logic [AW-1:0] wr_beg;
  logic [SW-1:0] wr_len;
  logic [SW-1:0] free_val;
  logic [SW-1:0] cfg_sat;

  assign req_end = EW'(start_r) + EW'(size_r);
  assign rd_end  = EW'(rd_beg_r) + EW'(rd_len_r);

  // Saturate a size write into 1 .. 2^INDEX_BITS
  always_comb begin
    cfg_sat = cfg_total;
    if (cfg_total == '0) cfg_sat = SW'(1);
    else if (cfg_total > bfea_pkg::TOTAL_MAX) cfg_sat = bfea_pkg::TOTAL_MAX;
  end

  // Capture size register and request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= bfea_pkg::TOTAL_MAX;
    end else if (cmd.cfg_load) begin
      total_r <= cfg_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      type_r  <= in_req_type;
      size_r  <= in_block_size;
      start_r <= in_block_start;
    end
  end

  // Update decision for the table
  always_comb begin
    st_nxt     = bfea_pkg::ST_OK;
    gstart_nxt = '0;
    gsize_nxt  = '0;
    wr_en      = 1'b0;
    wr_idx     = best_idx_r;
    wr_beg     = best_beg_r;
    wr_len     = best_len_r - size_r;
    clr_en     = 1'b0;
    clr_idx    = best_idx_r;
    set_en     = 1'b0;
    new_end    = aft_fnd_r ? EW'(aft_beg_r) + EW'(aft_len_r) : req_end;
    new_beg    = bef_fnd_r ? bef_beg_r : start_r;
    if (type_r == bfea_pkg::REQ_ALLOC) begin
      if (size_r == '0) begin
        st_nxt = bfea_pkg::ST_IGN;
      end else if (!best_fnd_r) begin
        st_nxt = bfea_pkg::ST_OOM;
      end else begin
        gstart_nxt = AW'(EW'(best_beg_r) + EW'(best_len_r) - EW'(size_r));
        gsize_nxt  = size_r;
        if (best_len_r == size_r) clr_en = 1'b1;
        else wr_en = 1'b1;
      end
    end else begin
      if (size_r == '0 || req_end > EW'(total_r)) begin
        st_nxt = bfea_pkg::ST_IGN;
      end else begin
        wr_beg = new_beg;
        wr_len = SW'(new_end - EW'(new_beg));
        if (bef_fnd_r && aft_fnd_r && bef_idx_r != aft_idx_r) begin
          clr_en  = 1'b1;
          clr_idx = aft_idx_r;
          wr_idx  = bef_idx_r;
          wr_en   = 1'b1;
        end else if (bef_fnd_r) begin
          wr_idx = bef_idx_r;
          wr_en  = 1'b1;
        end else if (aft_fnd_r) begin
          wr_idx = aft_idx_r;
          wr_en  = 1'b1;
        end else if (slot_fnd_r) begin
          wr_idx = slot_idx_r;
          wr_en  = 1'b1;
        end else begin
          st_nxt = bfea_pkg::ST_FULL;
        end
        set_en = wr_en;
      end
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      mem_beg[0] <= '0;
      mem_len[0] <= total_r;
    end else if (cmd.apply && wr_en) begin
      mem_beg[wr_idx] <= wr_beg;
      mem_len[wr_idx] <= wr_len;
    end
    if (cmd.rd_en) begin
      rd_beg_r <= mem_beg[cmd.rd_addr];
      rd_len_r <= mem_len[cmd.rd_addr];
      rd_val_r <= valid_r[cmd.rd_addr];
      rd_idx_r <= cmd.rd_addr;
      rd_sum_r <= cmd.rd_sum;
    end
  end

  // Entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      valid_r <= {{(bfea_pkg::MAX_EXTENTS-1){1'b0}}, 1'b1};
    end else if (cmd.apply) begin
      if (clr_en) valid_r[clr_idx] <= 1'b0;
      if (set_en) valid_r[wr_idx]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_pend_r <= 1'b0;
    else        rd_pend_r <= cmd.rd_en;
  end

  // Scan evaluation: best fit, neighbors, free slot, and recount
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.req_load) begin
      best_fnd_r <= 1'b0;
      aft_fnd_r  <= 1'b0;
      bef_fnd_r  <= 1'b0;
      slot_fnd_r <= 1'b0;
      sum_r      <= '0;
    end else if (rd_pend_r && rd_sum_r) begin
      if (rd_val_r) sum_r <= sum_r + bfea_pkg::SUM_W'(rd_len_r);
    end else if (rd_pend_r) begin
      if (type_r == bfea_pkg::REQ_ALLOC) begin
        if (rd_val_r && rd_len_r >= size_r &&
            (!best_fnd_r || rd_len_r < best_len_r ||
             (rd_len_r == best_len_r && rd_beg_r < best_beg_r))) begin
          best_fnd_r <= 1'b1;
          best_idx_r <= rd_idx_r;
          best_beg_r <= rd_beg_r;
          best_len_r <= rd_len_r;
        end
      end else if (!rd_val_r) begin
        if (!slot_fnd_r) begin
          slot_fnd_r <= 1'b1;
          slot_idx_r <= rd_idx_r;
        end
      end else begin
        if (!aft_fnd_r && EW'(rd_beg_r) == req_end) begin
          aft_fnd_r <= 1'b1;
          aft_idx_r <= rd_idx_r;
          aft_beg_r <= rd_beg_r;
          aft_len_r <= rd_len_r;
        end
        if (!bef_fnd_r && rd_end == EW'(start_r)) begin
          bef_fnd_r <= 1'b1;
          bef_idx_r <= rd_idx_r;
          bef_beg_r <= rd_beg_r;
        end
      end
    end
  end

  // Hold the outcome of the update
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      st_r     <= st_nxt;
      gstart_r <= gstart_nxt;
      gsize_r  <= gsize_nxt;
    end
  end

  assign free_val = (sum_r > bfea_pkg::SUM_W'(total_r)) ? total_r : SW'(sum_r);

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= st_r;
      out_gstart_r <= gstart_r;
      out_gsize_r  <= gsize_r;
      out_free_r   <= free_val;
      out_used_r   <= total_r - free_val;
    end
  end

  assign stat.out_busy     = out_valid_r && !out_ready;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_start = out_gstart_r;
  assign out_granted_size  = out_gsize_r;
  assign out_free_elements = out_free_r;
  assign out_used_elements = out_used_r;

endmodule

// File: rtl/best_fit_extent_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit extent allocator
// Free-extent table with best-fit allocation and coalescing release.
// ----------------------------------------------------------------------------
// Each request goes through these steps after it is accepted: one pass over
// the 64-entry extent table to find the best fit or the release neighbors and
// a free slot (all 64 entries are read, then the last entry is evaluated), an
// update of the table, a second pass to recount the free total (all 64
// entries are read, then the last entry is summed) and the load of the result
// register, both passes through the single read port of the table memory, one
// entry per cycle. The block is ready again in the cycle after the result is
// loaded; while a finished result waits on a stalled output, that load is held
// back. One request is in work at a time; a new request is taken while the
// previous result still waits in the output register. After reset and after
// every write of total_elements the table is rebuilt.
module best_fit_extent_allocator (
  input  logic            clk,
  input  logic            rst_n,
  bfea_req_if.sink        in_ch,
  bfea_rsp_if.source      out_ch,
  bfea_cfg_if.sink        cfg_ch
);

  bfea_pkg::ctrl_cmd_t  cmd;
  bfea_pkg::ctrl_stat_t stat;

  bfea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bfea_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_total         (cfg_ch.total_elements),
    .in_req_type       (in_ch.req_type),
    .in_block_size     (in_ch.block_size),
    .in_block_start    (in_ch.block_start),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_granted_start (out_ch.granted_start),
    .out_granted_size  (out_ch.granted_size),
    .out_free_elements (out_ch.free_elements),
    .out_used_elements (out_ch.used_elements)
  );

endmodule
